// ===== hdl/dcc_pkg.sv =====
// Shared types and constants for the DAG edge store with cycle check.
// Used by every module of the block and by its checker; no dependencies.
`default_nettype none

package dcc_pkg;

	localparam int NODE_COUNT = 32;
	localparam int NODE_W     = 5;
	localparam int CMD_W      = 3;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD           = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE        = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REVERSE       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CHECK_ADD     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CHECK_REVERSE = 3'd4;

	typedef logic [NODE_COUNT-1:0] row_t;
	typedef logic [NODE_W-1:0]     node_t;

	// Input transaction
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		node_t            from_node;
		node_t            to_node;
	} req_t;

	// Result transaction
	typedef struct packed {
		logic acyclic;
		logic status;
	} rsp_t;

	// Row memory access from the sequencer
	typedef struct packed {
		logic  rd_en;
		node_t rd_addr;
		logic  wr_en;
		node_t wr_addr;
		row_t  wr_data;
	} mem_req_t;

	// Finished result from the sequencer
	typedef struct packed {
		logic done;
		rsp_t rsp;
	} seq_res_t;

endpackage

`default_nettype wire

// ===== hdl/dcc_row_mem.sv =====
// Parent row memory: one parent mask per node, one read and one write a cycle.
// Per-row valid flags make unwritten rows read as empty after reset. Uses dcc_pkg.
`default_nettype none

module dcc_row_mem
	import dcc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mem_req_t mreq,
	output row_t          rd_data
);

	row_t                  rows_q [NODE_COUNT];
	logic [NODE_COUNT-1:0] vld_q;
	row_t                  rd_data_q;

	// Storage write, no reset on the array
	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			rows_q[mreq.wr_addr] <= mreq.wr_data;
		end
	end

	// Row valid flags and registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_data_q <= '0;
		end else begin
			if (mreq.wr_en) begin
				vld_q[mreq.wr_addr] <= 1'b1;
			end
			if (mreq.rd_en) begin
				rd_data_q <= vld_q[mreq.rd_addr] ? rows_q[mreq.rd_addr] : '0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/dcc_seq.sv =====
// Command sequencer and ancestor walk for the DAG edge store.
// Drives dcc_row_mem through mem_req_t; uses dcc_pkg.
`default_nettype none

module dcc_seq
	import dcc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire req_t     req,
	input  wire logic     out_free,
	output seq_res_t      res,
	output mem_req_t      mreq,
	input  wire row_t     rd_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_ROW, S_REV_RD, S_REV_WR, S_LOAD, S_PICK, S_EXP, S_OUT
	} state_t;

	state_t           state_q;
	logic [CMD_W-1:0] cmd_q;
	node_t            from_q;
	node_t            to_q;
	node_t            target_q;
	node_t            node_q;
	logic             skip_q;
	row_t             pending_q;
	row_t             reached_q;
	logic             acyclic_q;
	logic             status_q;

	logic  accept;
	logic  present;
	logic  hit;
	logic  walk_end;
	node_t pick_n;
	row_t  from_bit;
	row_t  to_bit;
	row_t  pick_bit;
	row_t  reach_any;
	row_t  exp_row;

	// Lowest set bit of a mask
	function automatic node_t lowest_bit(input row_t m);
		node_t n;
		n = '0;
		for (int i = NODE_COUNT - 1; i >= 0; i--) begin
			if (m[i]) begin
				n = node_t'(i);
			end
		end
		return n;
	endfunction

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);

	// Shared walk unit: pick, target hit and parent merge
	assign from_bit  = row_t'(1) << from_q;
	assign to_bit    = row_t'(1) << to_q;
	assign present   = rd_data[from_q];
	assign reach_any = reached_q | pending_q;
	assign hit       = reach_any[target_q];
	assign walk_end  = (pending_q == '0) || hit;
	assign pick_n    = lowest_bit(pending_q);
	assign pick_bit  = row_t'(1) << pick_n;

	always_comb begin
		exp_row = rd_data & ~reached_q;
		if (skip_q && (node_q == to_q)) begin
			exp_row = exp_row & ~from_bit;
		end
	end

	// Row memory requests
	always_comb begin
		mreq = '0;
		case (state_q)
			S_IDLE: begin
				mreq.rd_en   = accept;
				mreq.rd_addr = req.to_node;
			end
			S_ROW: begin
				mreq.wr_addr = to_q;
				mreq.rd_addr = from_q;
				case (cmd_q)
					CMD_ADD: begin
						mreq.wr_en   = 1'b1;
						mreq.wr_data = rd_data | from_bit;
					end
					CMD_DELETE, CMD_REVERSE: begin
						mreq.wr_en   = present;
						mreq.wr_data = rd_data & ~from_bit;
					end
					CMD_CHECK_ADD: begin
						mreq.rd_en = (from_q != to_q);
					end
					default: begin
					end
				endcase
			end
			S_REV_RD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = from_q;
			end
			S_REV_WR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = from_q;
				mreq.wr_data = rd_data | to_bit;
			end
			S_PICK: begin
				mreq.rd_en   = !walk_end;
				mreq.rd_addr = pick_n;
			end
			default: begin
			end
		endcase
	end

	assign res.done        = (state_q == S_OUT);
	assign res.rsp.acyclic = acyclic_q;
	assign res.rsp.status  = status_q;

	// Sequencer state and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cmd_q     <= '0;
			from_q    <= '0;
			to_q      <= '0;
			target_q  <= '0;
			node_q    <= '0;
			skip_q    <= 1'b0;
			pending_q <= '0;
			reached_q <= '0;
			acyclic_q <= 1'b0;
			status_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= req.cmd;
						from_q  <= req.from_node;
						to_q    <= req.to_node;
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					acyclic_q <= 1'b0;
					status_q  <= 1'b0;
					state_q   <= S_OUT;
					case (cmd_q)
						CMD_DELETE: begin
							status_q <= !present;
						end
						CMD_REVERSE: begin
							status_q <= !present;
							if (present) begin
								state_q <= S_REV_RD;
							end
						end
						CMD_CHECK_ADD: begin
							if (from_q != to_q) begin
								target_q  <= to_q;
								skip_q    <= 1'b0;
								reached_q <= '0;
								state_q   <= S_LOAD;
							end
						end
						CMD_CHECK_REVERSE: begin
							status_q <= !present;
							if (present && (from_q != to_q)) begin
								target_q  <= from_q;
								skip_q    <= 1'b1;
								reached_q <= '0;
								pending_q <= rd_data & ~from_bit;
								state_q   <= S_PICK;
							end
						end
						default: begin
						end
					endcase
				end
				S_REV_RD: begin
					state_q <= S_REV_WR;
				end
				S_REV_WR: begin
					state_q <= S_OUT;
				end
				S_LOAD: begin
					pending_q <= rd_data;
					state_q   <= S_PICK;
				end
				S_PICK: begin
					if (walk_end) begin
						acyclic_q <= !hit;
						state_q   <= S_OUT;
					end else begin
						pending_q <= pending_q & ~pick_bit;
						reached_q <= reached_q | pick_bit;
						node_q    <= pick_n;
						state_q   <= S_EXP;
					end
				end
				S_EXP: begin
					pending_q <= pending_q | exp_row;
					state_q   <= S_PICK;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/dag_edge_cycle_checker_top.sv =====
// DAG edge store with cycle check: top level with sequencer, row memory and output register.
// Add, delete and commands with no walk finish after the row access; reverse also reads and
// rewrites the from row; the checks then pick and expand ancestors one at a time (at most 32).
// Throughput: one transaction in flight; the next is taken the cycle after the result
// enters the output register. Reset (arst_n low, asynchronous): empty graph, sequencer idle,
// no result pending. Uses dcc_pkg, dcc_row_mem and dcc_seq.
`default_nettype none

module dag_edge_cycle_checker_top
	import dcc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	mem_req_t mreq;
	row_t     rd_data;
	seq_res_t res;
	logic     out_free;
	logic     rsp_valid_q;
	rsp_t     rsp_q;

	dcc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.out_free  (out_free),
		.res       (res),
		.mreq      (mreq),
		.rd_data   (rd_data)
	);

	dcc_row_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

	// Output register
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= res.done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.done) begin
			rsp_q <= res.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== hdl/dcc_checker.sv =====
// Port-level assertions for dag_edge_cycle_checker_top, attached by bind.
// Uses dcc_pkg.
`default_nettype none

module dcc_checker
	import dcc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// Block is busy in the cycle after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("input not stalled after accepted transaction");

	// A new result only appears after the block has stalled its input for work
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without work");

	// Acyclic is never reported together with an absent edge status
	a_acyclic_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.acyclic) |-> !rsp.status)
		else $error("acyclic reported together with absent edge status");

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

	// Stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_stall) |=> (req_valid && $stable(req)))
		else $error("stalled request changed");

endmodule

bind dag_edge_cycle_checker_top dcc_checker u_dcc_checker (.*);

`default_nettype wire

// ===== bench/tb_dag_edge_cycle_checker_top.sv =====
// Self-checking bench for the DAG edge store with cycle check: directed table, then random
// commands with an in-bench graph model. Depends on dcc_pkg and dag_edge_cycle_checker_top.
`default_nettype none

module tb_dag_edge_cycle_checker_top;
	import dcc_pkg::*;

	// Codes the block ignores
	localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

	localparam int RANDOM_ITEMS  = 1275;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int DIRECTED_N    = 25;
	localparam int VERDICT_DEPTH = 8;

	// One row of the directed table; fixed marks a verdict typed in by hand
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		node_t            src;
		node_t            dst;
		logic             fixed;
		logic             acyc;
		logic             stat;
	} edge_step_t;

	localparam edge_step_t EDGE_STEPS [DIRECTED_N] = '{
		'{CMD_CHECK_ADD,     5'd0,  5'd1,  1'b1, 1'b1, 1'b0}, // empty graph
		'{CMD_DELETE,        5'd0,  5'd1,  1'b1, 1'b0, 1'b1}, // absent edge
		'{CMD_REVERSE,       5'd0,  5'd1,  1'b1, 1'b0, 1'b1},
		'{CMD_CHECK_REVERSE, 5'd0,  5'd1,  1'b1, 1'b0, 1'b1},
		'{CMD_CHECK_ADD,     5'd5,  5'd5,  1'b1, 1'b0, 1'b0}, // self edge check
		'{CMD_ADD,           5'd0,  5'd1,  1'b1, 1'b0, 1'b0},
		'{CMD_ADD,           5'd0,  5'd1,  1'b1, 1'b0, 1'b0}, // already present
		'{CMD_ADD,           5'd1,  5'd2,  1'b1, 1'b0, 1'b0},
		'{CMD_CHECK_ADD,     5'd2,  5'd0,  1'b1, 1'b0, 1'b0}, // closes 0->1->2->0
		'{CMD_CHECK_ADD,     5'd0,  5'd2,  1'b1, 1'b1, 1'b0},
		'{CMD_CHECK_REVERSE, 5'd1,  5'd2,  1'b0, 1'b0, 1'b0},
		'{CMD_ADD,           5'd0,  5'd2,  1'b1, 1'b0, 1'b0},
		'{CMD_CHECK_REVERSE, 5'd0,  5'd2,  1'b0, 1'b0, 1'b0},
		'{CMD_REVERSE,       5'd1,  5'd2,  1'b1, 1'b0, 1'b0},
		'{CMD_UNUSED_5,      5'd31, 5'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_UNUSED_6,      5'd0,  5'd31, 1'b1, 1'b0, 1'b0},
		'{CMD_UNUSED_7,      5'd31, 5'd31, 1'b1, 1'b0, 1'b0},
		'{CMD_ADD,           5'd31, 5'd31, 1'b1, 1'b0, 1'b0}, // stored without check
		'{CMD_CHECK_REVERSE, 5'd31, 5'd31, 1'b1, 1'b0, 1'b0}, // present self edge
		'{CMD_ADD,           5'd31, 5'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_ADD,           5'd0,  5'd31, 1'b1, 1'b0, 1'b0}, // both directions
		'{CMD_CHECK_ADD,     5'd31, 5'd30, 1'b0, 1'b0, 1'b0}, // walk on a cyclic graph
		'{CMD_CHECK_REVERSE, 5'd0,  5'd31, 1'b0, 1'b0, 1'b0},
		'{CMD_DELETE,        5'd31, 5'd31, 1'b1, 1'b0, 1'b0},
		'{CMD_DELETE,        5'd0,  5'd31, 1'b1, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Bench graph model and result bookkeeping
	row_t graph_rows [NODE_COUNT];
	rsp_t pending_verdicts [VERDICT_DEPTH];
	int   verdicts_in;
	int   verdicts_out;
	int   mismatches;
	int   items_sent;
	int   results_seen;
	int   deepest_walk;
	int   cycles;
	int   gap_pct;
	int   stall_pct;
	int   hold_left;
	logic hold_done;

	dag_edge_cycle_checker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// Parents of node n, optionally without the edge skip_from -> skip_to
	function automatic row_t parents_without(node_t n, logic skip, node_t skip_from,
			node_t skip_to);
		row_t row;
		row = graph_rows[n];
		if (skip && n == skip_to)
			row[skip_from] = 1'b0;
		return row;
	endfunction

	// Ancestor walk with a visited mask; one node expanded per step
	function automatic logic is_upstream(node_t target, node_t start, logic skip,
			node_t skip_from, node_t skip_to);
		row_t  reached;
		row_t  waiting;
		node_t n;
		int    steps;
		reached = '0;
		waiting = parents_without(start, skip, skip_from, skip_to);
		steps = 0;
		while (steps < NODE_COUNT && waiting != '0) begin
			n = '0;
			for (int i = NODE_COUNT - 1; i >= 0; i--)
				if (waiting[i])
					n = node_t'(i);
			waiting[n] = 1'b0;
			reached[n] = 1'b1;
			waiting = waiting | (parents_without(n, skip, skip_from, skip_to) & ~reached);
			steps++;
		end
		if (steps > deepest_walk)
			deepest_walk = steps;
		return reached[target] | waiting[target];
	endfunction

	// Applies one command to the model graph and returns its verdict
	function automatic rsp_t apply_graph_command(req_t r);
		rsp_t res;
		logic present;
		res = '0;
		present = graph_rows[r.to_node][r.from_node];
		case (r.cmd)
			CMD_ADD: begin
				graph_rows[r.to_node][r.from_node] = 1'b1;
			end
			CMD_DELETE: begin
				if (present)
					graph_rows[r.to_node][r.from_node] = 1'b0;
				else
					res.status = 1'b1;
			end
			CMD_REVERSE: begin
				if (present) begin
					graph_rows[r.to_node][r.from_node] = 1'b0;
					graph_rows[r.from_node][r.to_node] = 1'b1;
				end else begin
					res.status = 1'b1;
				end
			end
			CMD_CHECK_ADD: begin
				if (r.from_node != r.to_node)
					res.acyclic = !is_upstream(r.to_node, r.from_node, 1'b0, '0, '0);
			end
			CMD_CHECK_REVERSE: begin
				if (!present)
					res.status = 1'b1;
				else if (r.from_node != r.to_node)
					res.acyclic = !is_upstream(r.from_node, r.to_node, 1'b1,
						r.from_node, r.to_node);
			end
			default: ;
		endcase
		return res;
	endfunction

	// Picks a stored edge at random; returns 0 on an empty graph
	function automatic logic pick_stored_edge(output node_t src, output node_t dst);
		int total;
		int target;
		int seen;
		total = 0;
		seen = 0;
		src = '0;
		dst = '0;
		for (int c = 0; c < NODE_COUNT; c++)
			total += $countones(graph_rows[c]);
		if (total == 0)
			return 1'b0;
		target = $urandom_range(total - 1);
		for (int c = 0; c < NODE_COUNT; c++)
			for (int p = 0; p < NODE_COUNT; p++)
				if (graph_rows[c][p]) begin
					if (seen == target) begin
						src = node_t'(p);
						dst = node_t'(c);
						return 1'b1;
					end
					seen++;
				end
		return 1'b0;
	endfunction

	// Random command, mostly naming stored edges where an edge must exist
	function automatic req_t random_command();
		req_t  r;
		int    pick;
		int    span;
		node_t src;
		node_t dst;
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0, 1:    span = 7;
			2:       span = 15;
			default: span = NODE_COUNT - 1;
		endcase
		r.from_node = node_t'($urandom_range(span));
		r.to_node   = node_t'($urandom_range(span));
		if (pick < 25) begin
			r.cmd = CMD_ADD;
			if ($urandom_range(3) == 0)
				r.to_node = r.from_node + 1'b1;
		end else if (pick < 45) begin
			r.cmd = CMD_DELETE;
		end else if (pick < 55) begin
			r.cmd = CMD_REVERSE;
		end else if (pick < 75) begin
			r.cmd = CMD_CHECK_ADD;
		end else if (pick < 95) begin
			r.cmd = CMD_CHECK_REVERSE;
		end else begin
			r.cmd = CMD_W'($urandom_range(CMD_UNUSED_5, CMD_UNUSED_7));
		end
		if ((r.cmd == CMD_DELETE || r.cmd == CMD_REVERSE || r.cmd == CMD_CHECK_REVERSE)
				&& $urandom_range(9) < 8) begin
			if (pick_stored_edge(src, dst)) begin
				r.from_node = src;
				r.to_node   = dst;
			end
		end
		return r;
	endfunction

	// Offers one transaction from a falling edge; returns at the falling edge after acceptance
	task automatic offer_command(input req_t item, input logic fixed, input rsp_t typed);
		rsp_t predicted;
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		predicted = apply_graph_command(item);
		pending_verdicts[verdicts_in[2:0]] = fixed ? typed : predicted;
		verdicts_in++;
		items_sent++;
		@(negedge clk);
	endtask

	task automatic offer_plain(input logic [CMD_W-1:0] cmd, input node_t src, input node_t dst);
		req_t r;
		r.cmd       = cmd;
		r.from_node = src;
		r.to_node   = dst;
		offer_command(r, 1'b0, '0);
	endtask

	// Stimulus
	initial begin
		req_t r;
		rsp_t typed;
		int   rnd;
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		verdicts_in  = 0;
		verdicts_out = 0;
		mismatches   = 0;
		items_sent   = 0;
		results_seen = 0;
		deepest_walk = 0;
		cycles       = 0;
		gap_pct      = 25;
		stall_pct    = 45;
		foreach (graph_rows[i])
			graph_rows[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table
		for (int i = 0; i < DIRECTED_N; i++) begin
			r.cmd         = EDGE_STEPS[i].cmd;
			r.from_node   = EDGE_STEPS[i].src;
			r.to_node     = EDGE_STEPS[i].dst;
			typed.acyclic = EDGE_STEPS[i].acyc;
			typed.status  = EDGE_STEPS[i].stat;
			offer_command(r, EDGE_STEPS[i].fixed, typed);
		end

		// Random part, with a full-length chain built now and then
		rnd = 0;
		while (rnd < RANDOM_ITEMS) begin
			if (items_sent >= 900) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else if (items_sent >= 450) begin
				gap_pct   = 45;
				stall_pct = 25;
			end
			if (rnd % 200 == 100) begin
				for (int n = 0; n < NODE_COUNT - 1; n++)
					offer_plain(CMD_ADD, node_t'(n), node_t'(n + 1));
				offer_plain(CMD_CHECK_ADD, node_t'(NODE_COUNT - 1), '0);
				offer_plain(CMD_CHECK_ADD, '0, node_t'(NODE_COUNT - 1));
				offer_plain(CMD_CHECK_REVERSE, node_t'($urandom_range(NODE_COUNT - 2)),
					node_t'(0));
				rnd += NODE_COUNT + 2;
			end else begin
				offer_command(random_command(), 1'b0, '0);
				rnd++;
			end
		end
		req_valid <= 1'b0;

		while (verdicts_in != verdicts_out)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transactions (%0d from the table), %0d results checked.",
			items_sent, DIRECTED_N, results_seen);
		$display("Longest ancestor walk: %0d nodes; %0d mismatches.", deepest_walk, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Result side stall, with one long hold-off once the idle-free phase is under way
	initial begin
		rsp_stall = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 1000) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (verdicts_out == verdicts_in) begin
				$error("result with no transaction outstanding: acyclic %0b status %0b",
					rsp.acyclic, rsp.status);
				mismatches++;
			end else begin
				want = pending_verdicts[verdicts_out[2:0]];
				verdicts_out++;
				if (rsp.acyclic !== want.acyclic) begin
					$error("acyclic: expected %0b, got %0b", want.acyclic, rsp.acyclic);
					mismatches++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0b, got %0b", want.status, rsp.status);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/dcc_pkg.sv
hdl/dcc_row_mem.sv
hdl/dcc_seq.sv
hdl/dag_edge_cycle_checker_top.sv
hdl/dcc_checker.sv
bench/tb_dag_edge_cycle_checker_top.sv
